### rtl/efa_pkg.sv
// shared widths, codes and controller/datapath bundles for the fade animator
`timescale 1ns / 1ps

package efa_pkg;

    // fixed field widths
    localparam int TARGET_W   = 17;
    localparam int TICK_W     = 16;
    localparam int LEVEL_W    = 16;
    localparam int DUR_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // duration after reset, in ms
    localparam logic [DUR_W-1:0] DUR_RESET = 16'd250;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE = 1'b1;

    // input item kinds
    localparam logic KIND_RETARGET = 1'b0;
    localparam logic KIND_TICK     = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        EASE_LINEAR      = 2'd0,
        EASE_OUT_QUAD    = 2'd1,
        EASE_IN_OUT_QUAD = 2'd2,
        EASE_OUT_CUBIC   = 2'd3
    } ease_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul_first;
        logic mul_second;
        logic ease_apply;
        logic load_out;
    } efa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic  need_div;
        ease_t mode;
    } efa_stat_t;

endpackage

### rtl/efa_if.sv
// valid/ready channel interfaces for input items and results
`timescale 1ns / 1ps

interface efa_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [efa_pkg::TARGET_W-1:0] target_level;
    logic        [efa_pkg::TICK_W-1:0]   tick_ms;

    modport source (output valid, output kind, output target_level, output tick_ms,
                    input ready);
    modport sink   (input valid, input kind, input target_level, input tick_ms,
                    output ready);
endinterface

interface efa_out_if;
    logic                         valid;
    logic                         ready;
    logic [efa_pkg::LEVEL_W-1:0]  level;
    logic                         busy_res;

    modport source (output valid, output level, output busy_res, input ready);
    modport sink   (input valid, input level, input busy_res, output ready);
endinterface

### rtl/efa_datapath.sv
// fade animator datapath: state, config, restoring divider, shared multiplier, easing
`timescale 1ns / 1ps

module efa_datapath #(
    parameter int FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                kind,
    input  logic signed [efa_pkg::TARGET_W-1:0] target_level,
    input  logic [efa_pkg::TICK_W-1:0]          tick_ms,
    input  efa_pkg::efa_cmd_t                   cmd,
    output efa_pkg::efa_stat_t                  stat,
    output logic [efa_pkg::LEVEL_W-1:0]         level,
    output logic                                busy_res
);
    import efa_pkg::*;

    localparam int LW = FRAC_BITS + 1;
    localparam int CW = (LW > LEVEL_W) ? LW : LEVEL_W;
    localparam int PW = 2 * LW;
    localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // architectural state
    logic [LW-1:0]        cur_level_reg;
    logic [LW-1:0]        goal_level_reg;
    logic [DUR_W-1:0]     elapsed_reg;
    logic                 running_reg;
    logic [DUR_W-1:0]     dur_reg;
    ease_t                mode_reg;

    // working registers
    logic [DUR_W-1:0]     rem_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [LW-1:0]        p_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic                 out_busy_reg;

    // target clamp to 0..ONE
    logic [CW-1:0] raw_mag;
    logic [LW-1:0] goal_clamp;
    always_comb
    begin
        raw_mag = CW'(target_level[TARGET_W-2:0]);
        if (target_level[TARGET_W-1])
            goal_clamp = '0;
        else if (raw_mag > CW'(ONE))
            goal_clamp = ONE;
        else
            goal_clamp = LW'(raw_mag);
    end

    // elapsed time update and end test
    logic [DUR_W:0] tick_sum;
    logic           reach;
    assign tick_sum = {1'b0, elapsed_reg} + {1'b0, tick_ms};
    assign reach    = (tick_sum >= {1'b0, dur_reg});

    assign stat.need_div = (kind == KIND_TICK) && running_reg && !reach;
    assign stat.mode     = mode_reg;

    // one restoring division step
    logic [DUR_W:0] rem_sh;
    logic [DUR_W:0] rem_diff;
    logic           q_bit;
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_diff = rem_sh - {1'b0, dur_reg};
    assign q_bit    = (rem_sh >= {1'b0, dur_reg});

    // ease operands
    logic [LW-1:0] t_ext;
    logic [LW-1:0] k_val;
    logic [LW:0]   k_dbl;
    logic [LW-1:0] two_t;
    logic          t_upper;
    assign t_ext   = {1'b0, q_reg};
    assign k_val   = ONE - t_ext;
    assign k_dbl   = {k_val, 1'b0};
    assign two_t   = {q_reg, 1'b0};
    assign t_upper = q_reg[FRAC_BITS-1];

    // shared multiplier, product scaled back by FRAC_BITS
    logic [LW-1:0] mul_a;
    logic [LW-1:0] mul_b;
    logic [PW-1:0] prod;
    logic [LW-1:0] prod_sh;
    always_comb
    begin
        mul_a = k_val;
        mul_b = k_val;
        if (cmd.mul_second)
        begin
            mul_a = p_reg;
            mul_b = k_val;
        end
        else if (mode_reg == EASE_IN_OUT_QUAD)
        begin
            if (t_upper)
            begin
                mul_a = k_dbl[LW-1:0];
                mul_b = k_dbl[LW-1:0];
            end
            else
            begin
                mul_a = two_t;
                mul_b = t_ext;
            end
        end
    end
    assign prod    = PW'(mul_a) * PW'(mul_b);
    assign prod_sh = prod[FRAC_BITS +: LW];

    // eased value and new level
    logic [LW-1:0] ease_val;
    logic [LW-1:0] level_new;
    always_comb
    begin
        case (mode_reg)
            EASE_LINEAR:      ease_val = t_ext;
            EASE_OUT_QUAD:    ease_val = ONE - p_reg;
            EASE_IN_OUT_QUAD: ease_val = t_upper ? (ONE - (p_reg >> 1)) : p_reg;
            EASE_OUT_CUBIC:   ease_val = ONE - p_reg;
            default:          ease_val = t_ext;
        endcase
        level_new = (goal_level_reg == ONE) ? ease_val : (ONE - ease_val);
    end

    logic [CW-1:0] cur_ext;
    assign cur_ext = CW'(cur_level_reg);

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_level_reg  <= '0;
            goal_level_reg <= '0;
            elapsed_reg    <= DUR_RESET;
            running_reg    <= 1'b0;
            dur_reg        <= DUR_RESET;
            mode_reg       <= EASE_LINEAR;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DURATION:
                        dur_reg <= (cfg_data[DUR_W-1:0] == '0) ? DUR_W'(1)
                                                               : cfg_data[DUR_W-1:0];
                    REG_EASE_MODE:
                        mode_reg <= ease_t'(cfg_data[MODE_W-1:0]);
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                if (kind == KIND_RETARGET)
                begin
                    goal_level_reg <= goal_clamp;
                    elapsed_reg    <= '0;
                    running_reg    <= (cur_level_reg != goal_clamp);
                end
                else if (running_reg)
                begin
                    if (reach)
                    begin
                        elapsed_reg   <= dur_reg;
                        cur_level_reg <= goal_level_reg;
                        running_reg   <= 1'b0;
                    end
                    else
                        elapsed_reg <= tick_sum[DUR_W-1:0];
                end
            end
            if (cmd.ease_apply)
                cur_level_reg <= level_new;
        end
    end

    // divider, product and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rem_reg <= tick_sum[DUR_W-1:0];
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_diff[DUR_W-1:0] : rem_sh[DUR_W-1:0];
        end
        if (cmd.div_step)
            q_reg <= {q_reg[FRAC_BITS-2:0], q_bit};
        if (cmd.mul_first || cmd.mul_second)
            p_reg <= prod_sh;
        if (cmd.load_out)
        begin
            out_level_reg <= cur_ext[LEVEL_W-1:0];
            out_busy_reg  <= running_reg;
        end
    end

    assign level    = out_level_reg;
    assign busy_res = out_busy_reg;

endmodule

### rtl/efa_ctrl.sv
// fade animator sequencer: item acceptance, divide loop, multiply steps, result hand-off
`timescale 1ns / 1ps

module efa_ctrl #(
    parameter int FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  efa_pkg::efa_stat_t stat,
    output efa_pkg::efa_cmd_t  cmd
);
    import efa_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_EASE,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = stat.need_div ? S_DIV : S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = (stat.mode == EASE_LINEAR) ? S_EASE : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_first = 1'b1;
                state_next    = (stat.mode == EASE_OUT_CUBIC) ? S_MUL2 : S_EASE;
            end
            S_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = S_EASE;
            end
            S_EASE:
            begin
                cmd.ease_apply = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/easing_fade_animator.sv
// top level of the eased fade level animator
`timescale 1ns / 1ps

// Usage: input transactions on in_ch are either a retarget (kind 0, target_level
// clamped to 0..1.0) or a time tick (kind 1, tick_ms). Each input transaction
// yields exactly one result transaction on out_ch with the current level in
// Q1.FRAC_BITS and busy_res. duration and ease_mode are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle; the block itself does not enforce this.
// Sequence: a retarget, an idle tick or a tick that ends the animation goes
// straight to the result step. A tick mid-animation runs the restoring divider
// over FRAC_BITS quotient bits, then 0 to 2 passes of the shared multiplier
// (none for linear, two for out-cubic) and one easing step.
// Throughput: one item at a time; in_ch is ready again the cycle after the
// result is loaded. The divider loop yields one quotient bit per cycle.
// Reset: level 0, idle, duration 250 ms, linear easing.
// Stalls: one result register; the next item is accepted while a result waits,
// and its own result is held back until the waiting one is taken.

module easing_fade_animator #(
    parameter int FRAC_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0] cfg_data,
    efa_in_if.sink                         in_ch,
    efa_out_if.source                      out_ch
);
    import efa_pkg::*;

    efa_cmd_t  cmd;
    efa_stat_t stat;

    // sequencer
    efa_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and state
    efa_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (in_ch.kind),
        .target_level (in_ch.target_level),
        .tick_ms      (in_ch.tick_ms),
        .cmd          (cmd),
        .stat         (stat),
        .level        (out_ch.level),
        .busy_res     (out_ch.busy_res)
    );

endmodule

### verif/tb_easing_fade_animator.sv
// self-checking testbench for the eased fade level animator
`timescale 1ns / 1ps

// expected-level tracker: mirrors the animator state and queues the expected results
class fade_scoreboard #(int FB = 15);
    localparam bit [63:0] ONE = 64'd1 << FB;

    bit [15:0]        dur;
    efa_pkg::ease_t   mode;
    bit [63:0]        level_now;
    bit [63:0]        goal;
    bit [15:0]        elapsed;
    bit               running;
    bit [15:0]        level_due[$];
    bit               busy_due[$];
    int               errors;

    function new();
        dur       = efa_pkg::DUR_RESET;
        mode      = efa_pkg::EASE_LINEAR;
        level_now = '0;
        goal      = '0;
        elapsed   = efa_pkg::DUR_RESET;
        running   = 1'b0;
        errors    = 0;
    endfunction

    // a duration of zero is stored as one
    function void set_duration(bit [15:0] d);
        dur = (d == 16'd0) ? 16'd1 : d;
    endfunction

    function void set_mode(bit [15:0] d);
        mode = efa_pkg::ease_t'(d[1:0]);
    endfunction

    // eased fraction for t in 0..ONE, products truncate
    function bit [63:0] eased_fraction(bit [63:0] t);
        bit [63:0] k;
        bit [63:0] k2;
        bit [63:0] m;
        bit [63:0] e;
        k = ONE - t;
        case (mode)
            efa_pkg::EASE_OUT_QUAD:
                e = ONE - ((k * k) >> FB);
            efa_pkg::EASE_IN_OUT_QUAD:
                if (t < (ONE >> 1))
                begin
                    e = (64'd2 * t * t) >> FB;
                end
                else
                begin
                    m = 64'd2 * k;
                    e = ONE - (((m * m) >> FB) >> 1);
                end
            efa_pkg::EASE_OUT_CUBIC:
            begin
                k2 = (k * k) >> FB;
                e  = ONE - ((k2 * k) >> FB);
            end
            default:
                e = t;
        endcase
        return e;
    endfunction

    // advance the tracked state by one accepted input transaction
    function void note_item(bit kind, bit [16:0] tgt, bit [15:0] tick);
        bit [31:0] sum;
        bit [63:0] t;
        bit [63:0] e;
        if (kind == efa_pkg::KIND_RETARGET)
        begin
            // negative targets clamp to zero, anything above 1.0 to 1.0
            if (tgt[16])
                goal = '0;
            else if (64'(tgt) > ONE)
                goal = ONE;
            else
                goal = 64'(tgt);
            elapsed = '0;
            running = (level_now != goal);
        end
        else if (running)
        begin
            sum = 32'(elapsed) + 32'(tick);
            if (sum >= 32'(dur))
            begin
                elapsed   = dur;
                level_now = goal;
                running   = 1'b0;
            end
            else
            begin
                elapsed   = sum[15:0];
                t         = (64'(sum) << FB) / 64'(dur);
                e         = eased_fraction(t);
                level_now = (goal == ONE) ? e : ONE - e;
            end
        end
        level_due.push_back(level_now[15:0]);
        busy_due.push_back(running);
    endfunction

    task report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // compare one result transaction with the oldest expectation
    task check_result(bit [15:0] level, bit busy);
        bit [15:0] want_level;
        bit        want_busy;
        if (level_due.size() == 0)
        begin
            report($sformatf("unexpected result level=%0d busy=%0b", level, busy));
            return;
        end
        want_level = level_due.pop_front();
        want_busy  = busy_due.pop_front();
        if (level != want_level)
            report($sformatf("level got %0d want %0d", level, want_level));
        if (busy != want_busy)
            report($sformatf("busy_res got %0b want %0b", busy, want_busy));
    endtask
endclass

module tb_easing_fade_animator;
    import efa_pkg::*;

    localparam int FRAC        = 15;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [16:0] TGT_ONE = 17'h08000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    fade_scoreboard #(FRAC) sb;

    efa_in_if  in_ch ();
    efa_out_if out_ch ();

    easing_fade_animator #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result receiver with random stalls
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_item(in_ch.kind, in_ch.target_level, in_ch.tick_ms);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.level, out_ch.busy_res);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_easing_fade_animator: done, errors");
        $finish;
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic kind, input logic [16:0] tgt, input logic [15:0] ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.target_level <= tgt;
        in_ch.tick_ms      <= ms;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic retarget(input logic [16:0] tgt);
        send_item(KIND_RETARGET, tgt, 16'($urandom));
    endtask

    task automatic tick(input logic [15:0] ms);
        send_item(KIND_TICK, 17'($urandom), ms);
    endtask

    // stop sending, wait for every expected result, then let the block go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        // let the monitor log the last accepted transaction first
        @(posedge clk);
        while (sb.level_due.size() != 0)
            @(posedge clk);
        repeat (FRAC + 6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DURATION)
            sb.set_duration(data);
        else
            sb.set_mode(data);
        @(posedge clk);
    endtask

    // directed items: field extremes, every ease and the corner cases
    task automatic run_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // tick while idle, retargets to the current level, clamping
        tick(16'd5);
        retarget(17'h00000);
        retarget(17'h1FFFF);
        retarget(17'h0FFFF);
        // linear ramp up to the end of the duration
        tick(16'd0);
        tick(16'd100);
        tick(16'd149);
        tick(16'd1);
        // most negative target, then a long tick past the 16-bit range
        retarget(17'h10000);
        tick(16'd125);
        tick(16'hFFFF);

        settle();
        write_reg(REG_EASE_MODE, 16'(EASE_OUT_QUAD));
        retarget(TGT_ONE);
        tick(16'd60);
        tick(16'd200);

        // in-out quad on both halves, fading down to a partial level
        settle();
        write_reg(REG_EASE_MODE, 16'(EASE_IN_OUT_QUAD));
        retarget(17'd20000);
        tick(16'd50);
        tick(16'd100);
        tick(16'd100);

        settle();
        write_reg(REG_EASE_MODE, 16'(EASE_OUT_CUBIC));
        retarget(TGT_ONE);
        tick(16'd80);

        // zero duration is stored as one
        settle();
        write_reg(REG_DURATION, 16'd0);
        retarget(17'h00000);
        tick(16'd0);
        tick(16'd1);

        // duration shortened mid-animation ends it on the next tick
        settle();
        write_reg(REG_DURATION, 16'hFFFF);
        retarget(TGT_ONE);
        tick(16'hFFFE);
        settle();
        write_reg(REG_DURATION, 16'd100);
        tick(16'd0);
    endtask

    // random phase: mostly retarget-then-ticks sequences, some noise
    task automatic run_phase(input int p, input int n);
        int          sent;
        int          reps;
        int unsigned r;
        int unsigned d;
        logic [15:0] dur_data;
        logic [16:0] tgt;
        logic [15:0] ms;
        ease_t       mode;

        settle();
        case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
        case (p)
            0:       dur_data = 16'd0;
            1:       dur_data = 16'hFFFF;
            2:       dur_data = 16'd3;
            3:       dur_data = DUR_RESET;
            4:       dur_data = 16'($urandom_range(1, 40));
            5:       dur_data = 16'($urandom);
            6:       dur_data = 16'd1000;
            default: dur_data = 16'($urandom_range(1, 300));
        endcase
        mode = ease_t'((p + p / 4) % 4);
        write_reg(REG_DURATION, dur_data);
        write_reg(REG_EASE_MODE, {14'($urandom), mode});

        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 85)
            begin
                // target: mostly full scale or zero, some in between, some raw
                r = $urandom_range(99);
                if (r < 40)
                    tgt = TGT_ONE;
                else if (r < 65)
                    tgt = 17'h00000;
                else if (r < 85)
                    tgt = 17'($urandom_range(0, 32768));
                else
                    tgt = 17'($urandom);
                retarget(tgt);
                sent++;
                reps = $urandom_range(1, 12);
                repeat (reps)
                begin
                    // tick sizes scaled to the duration so animations span several ticks
                    d = sb.dur;
                    r = $urandom_range(99);
                    if (r < 70)
                        ms = 16'($urandom_range(0, d / 4 + 1));
                    else if (r < 80)
                        ms = 16'd0;
                    else if (r < 90)
                        ms = 16'($urandom);
                    else
                        ms = 16'($urandom_range(0, d));
                    tick(ms);
                    sent++;
                end
            end
            else
            begin
                send_item(1'($urandom), 17'($urandom), 16'($urandom));
                sent++;
            end
            // occasional pause until everything outstanding has come back
            if ($urandom_range(99) < 3)
                settle();
        end
    endtask

    // main sequence
    initial
    begin
        sb                 = new();
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_DURATION;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_RETARGET;
        in_ch.target_level = '0;
        in_ch.tick_ms      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < 8; p++)
            run_phase(p, 100);
        settle();

        if (sb.errors == 0)
            $display("tb_easing_fade_animator: done, clean");
        else
            $display("tb_easing_fade_animator: done, errors");
        $finish;
    end
endmodule
